// ----- src/ptsch_pkg.sv -----
`timescale 1ns / 1ps
package ptsch_pkg;

  // event kinds
  localparam logic [2:0] FN_CREATE    = 3'd0;
  localparam logic [2:0] FN_ACTIVATE  = 3'd1;
  localparam logic [2:0] FN_TERMINATE = 3'd2;
  localparam logic [2:0] FN_SLEEP     = 3'd3;
  localparam logic [2:0] FN_TICK      = 3'd4;

  // result status codes
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_PARAM = 2'd1;
  localparam logic [1:0] RES_ID    = 2'd2;
  localparam logic [1:0] RES_STATE = 2'd3;

  // per-thread state codes
  localparam logic [1:0] TS_DEAD    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;
  localparam logic [1:0] TS_WAITING = 2'd3;

  // thread index source for the table port
  typedef enum logic [2:0] {
    SEL_ID   = 3'd0,
    SEL_CUR  = 3'd1,
    SEL_MADE = 3'd2,
    SEL_SCAN = 3'd3,
    SEL_POP  = 3'd4
  } sel_t;

  typedef struct packed {
    logic       load;
    sel_t       sel;
    logic       wr_status;
    logic [1:0] st_val;
    logic       wr_prio;
    logic       push;
    logic       make;
    logic       set_res;
    logic [1:0] res;
    logic       sleep_wr;
    logic       scan_init;
    logic       scan_rd;
    logic       scan_wr;
    logic       scan_next;
    logic       save_prio;
    logic       pop_rd;
    logic       set_cur;
    logic       cur_idle;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       id_bad;
    logic       id_zero;
    logic       cur_zero;
    logic       ticks_zero;
    logic       prio_zero;
    logic       table_full;
    logic [1:0] sel_state;
    logic       prio_gt;
    logic       any_q;
    logic       scan_last;
    logic       dec_zero;
    logic       woke;
    logic       out_free;
  } sts_t;

endpackage

// ----- src/priority_thread_scheduler.sv -----
`timescale 1ns / 1ps
// Hardware thread scheduler with three FIFO ready queues (low, normal, high).
// Input channel in_*: one word per event (create, activate, terminate, sleep
// current thread, tick). Output channel out_*: exactly one word per event
// carrying status, the created index, the running thread and a switch flag.
// Events are handled one at a time; in_tready is high only while the
// sequencer waits for a new event, from the cycle after the result word is loaded.
// A rescheduling pass pops queue entries until it finds a ready thread, with
// stale entries costing a pop each, and runs the idle thread when the queues
// run dry. A tick walks threads 1..created-1 with an extra read step for each
// sleeping thread, since the sleep counters sit in a memory with registered read.
// Reset: thread 1 runs at normal priority, thread 0 is the idle thread,
// two threads exist, all queues are empty.
// Stall: the result sits in an output register; the next event is accepted
// while it waits, and its result is held back until the register is free.
module priority_thread_scheduler #(
  parameter int MAX_THREADS = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[2:0], thread_id[6:3], prio[8:7], ticks[40:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], new_thread_id[5:2],
                                  // running_thread[9:6], switched[10]
);
  ptsch_pkg::cmd_t cmd;
  ptsch_pkg::sts_t sts;
  logic [1:0]      res_status;
  logic [3:0]      res_new_id, res_running;
  logic            res_switched;

  ptsch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptsch_dp #(.MAX_THREADS(MAX_THREADS), .TICK_BITS(TICK_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_tdata[2:0]),
    .in_thread_id (in_tdata[6:3]),
    .in_prio      (in_tdata[8:7]),
    .in_ticks     (in_tdata[40:9]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (res_status),
    .out_new_id   (res_new_id),
    .out_running  (res_running),
    .out_switched (res_switched)
  );

  // pack the result word
  assign out_tdata = {5'd0, res_switched, res_running, res_new_id, res_status};
endmodule

// ----- src/ptsch_ram.sv -----
`timescale 1ns / 1ps
module ptsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- src/ptsch_ctrl.sv -----
`timescale 1ns / 1ps
module ptsch_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ptsch_pkg::sts_t sts,
  output ptsch_pkg::cmd_t cmd
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_ACTCMP = 9'b000000100,
    S_TRD    = 9'b000001000,
    S_TWR    = 9'b000010000,
    S_SCHED  = 9'b000100000,
    S_POP    = 9'b001000000,
    S_PCHK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of one event
  always_comb begin
    cmd       = '0;
    cmd.sel   = ptsch_pkg::SEL_ID;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (sts.func)
          ptsch_pkg::FN_CREATE: begin
            cmd.sel = ptsch_pkg::SEL_MADE;
            if (sts.prio_zero || sts.table_full) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_PARAM;
            end else begin
              cmd.wr_prio = 1'b1;
              cmd.make    = 1'b1;
            end
          end
          ptsch_pkg::FN_ACTIVATE: begin
            if (sts.id_bad) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_ID;
            end else if (sts.id_zero || sts.sel_state != ptsch_pkg::TS_DEAD) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_STATE;
            end else begin
              cmd.wr_status = 1'b1;
              cmd.st_val    = ptsch_pkg::TS_READY;
              cmd.push      = 1'b1;
              cmd.save_prio = 1'b1;
              state_nxt     = S_ACTCMP;
            end
          end
          ptsch_pkg::FN_TERMINATE: begin
            if (sts.id_bad) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_ID;
            end else if (sts.sel_state == ptsch_pkg::TS_DEAD) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_STATE;
            end else begin
              cmd.wr_status = 1'b1;
              cmd.st_val    = ptsch_pkg::TS_DEAD;
              state_nxt     = S_SCHED;
            end
          end
          ptsch_pkg::FN_SLEEP: begin
            cmd.sel = ptsch_pkg::SEL_CUR;
            if (sts.ticks_zero) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_PARAM;
            end else if (sts.cur_zero) begin
              cmd.set_res = 1'b1;
              cmd.res     = ptsch_pkg::RES_STATE;
            end else begin
              cmd.sleep_wr  = 1'b1;
              cmd.wr_status = 1'b1;
              cmd.st_val    = ptsch_pkg::TS_WAITING;
              state_nxt     = S_SCHED;
            end
          end
          ptsch_pkg::FN_TICK: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_TRD;
          end
          default: begin
            cmd.set_res = 1'b1;
            cmd.res     = ptsch_pkg::RES_PARAM;
          end
        endcase
      end
      S_ACTCMP: begin
        cmd.sel   = ptsch_pkg::SEL_CUR;
        state_nxt = sts.prio_gt ? S_SCHED : S_DONE;
      end
      S_TRD: begin
        cmd.sel = ptsch_pkg::SEL_SCAN;
        if (sts.sel_state == ptsch_pkg::TS_WAITING) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_TWR;
        end else if (sts.scan_last) begin
          state_nxt = sts.woke ? S_SCHED : S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_TWR: begin
        cmd.sel     = ptsch_pkg::SEL_SCAN;
        cmd.scan_wr = 1'b1;
        if (sts.dec_zero) begin
          cmd.wr_status = 1'b1;
          cmd.st_val    = ptsch_pkg::TS_READY;
          cmd.push      = 1'b1;
        end
        if (sts.scan_last) begin
          state_nxt = (sts.woke || sts.dec_zero) ? S_SCHED : S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_TRD;
        end
      end
      S_SCHED: begin
        // running thread goes back to its queue
        cmd.sel = ptsch_pkg::SEL_CUR;
        if (!sts.cur_zero && sts.sel_state == ptsch_pkg::TS_RUNNING) begin
          cmd.wr_status = 1'b1;
          cmd.st_val    = ptsch_pkg::TS_READY;
          cmd.push      = 1'b1;
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.any_q) begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_PCHK;
        end else begin
          cmd.cur_idle = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_PCHK: begin
        // stale entries are dropped
        cmd.sel = ptsch_pkg::SEL_POP;
        if (sts.sel_state == ptsch_pkg::TS_READY) begin
          cmd.wr_status = 1'b1;
          cmd.st_val    = ptsch_pkg::TS_RUNNING;
          cmd.set_cur   = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// ----- src/ptsch_dp.sv -----
`timescale 1ns / 1ps
module ptsch_dp #(
  parameter int MAX_THREADS = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      in_func,
  input  logic [3:0]      in_thread_id,
  input  logic [1:0]      in_prio,
  input  logic [31:0]     in_ticks,
  input  ptsch_pkg::cmd_t cmd,
  output ptsch_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [3:0]      out_new_id,
  output logic [3:0]      out_running,
  output logic            out_switched
);
  localparam int TID_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int QD    = 3 * MAX_THREADS;
  localparam int QA_W  = $clog2(QD);

  logic [2:0]           func_r;
  logic [3:0]           id_r;
  logic [1:0]           prio_in_r;
  logic [TICK_BITS-1:0] ticks_r;
  logic [TID_W-1:0]     cur_r, before_r, newid_r, scan_r;
  logic [CNT_W-1:0]     made_r;
  logic [1:0]           st_r [MAX_THREADS];
  logic [1:0]           pr_r [MAX_THREADS];
  logic [TID_W-1:0]     head_r [3];
  logic [TID_W-1:0]     tail_r [3];
  logic [CNT_W-1:0]     fill_r [3];
  logic                 woke_r;
  logic [1:0]           pid_r, res_r;
  logic                 out_valid_r, out_switched_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_new_id_r, out_running_r;

  logic [TID_W+3:0]     id_w;
  logic [TID_W-1:0]     sel;
  logic [1:0]           sel_state, sel_prio;
  logic [1:0]           pq, hq;
  logic                 push_ok, any_q;
  logic [TID_W-1:0]     q_rdata;
  logic [QA_W-1:0]      q_waddr, q_raddr;
  logic [TICK_BITS-1:0] s_rdata, s_wdata, dec;
  logic [TID_W-1:0]     s_waddr;

  // table port address
  assign id_w = (TID_W + 4)'(id_r);
  always_comb begin
    case (cmd.sel)
      ptsch_pkg::SEL_ID:   sel = id_w[TID_W-1:0];
      ptsch_pkg::SEL_CUR:  sel = cur_r;
      ptsch_pkg::SEL_MADE: sel = made_r[TID_W-1:0];
      ptsch_pkg::SEL_SCAN: sel = scan_r;
      ptsch_pkg::SEL_POP:  sel = q_rdata;
      default:             sel = cur_r;
    endcase
  end
  assign sel_state = st_r[sel];
  assign sel_prio  = pr_r[sel];

  // push target queue and highest non-empty queue
  assign pq      = (sel_prio == 2'd0) ? 2'd0 : sel_prio - 2'd1;
  assign push_ok = cmd.push && (sel_prio != 2'd0) &&
                   (fill_r[pq] != CNT_W'(MAX_THREADS));
  assign any_q   = (fill_r[0] != '0) || (fill_r[1] != '0) || (fill_r[2] != '0);
  assign hq      = (fill_r[2] != '0) ? 2'd2 : ((fill_r[1] != '0) ? 2'd1 : 2'd0);
  assign q_waddr = QA_W'(pq) * QA_W'(MAX_THREADS) + QA_W'(tail_r[pq]);
  assign q_raddr = QA_W'(hq) * QA_W'(MAX_THREADS) + QA_W'(head_r[hq]);

  ptsch_ram #(.WIDTH(TID_W), .DEPTH(QD)) u_ready_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (q_waddr),
    .wdata (sel),
    .re    (cmd.pop_rd),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // sleep counters
  assign dec     = s_rdata - TICK_BITS'(1);
  assign s_waddr = cmd.sleep_wr ? cur_r : scan_r;
  assign s_wdata = cmd.sleep_wr ? ticks_r : dec;

  ptsch_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_THREADS)) u_sleep_ram (
    .clk   (clk),
    .we    (cmd.sleep_wr || cmd.scan_wr),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (cmd.scan_rd),
    .raddr (scan_r),
    .rdata (s_rdata)
  );

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.id_bad     = 32'(id_r) >= 32'(made_r);
    sts.id_zero    = (id_r == 4'd0);
    sts.cur_zero   = (cur_r == '0);
    sts.ticks_zero = (ticks_r == '0);
    sts.prio_zero  = (prio_in_r == 2'd0);
    sts.table_full = (made_r >= CNT_W'(MAX_THREADS));
    sts.sel_state  = sel_state;
    sts.prio_gt    = (pid_r > sel_prio);
    sts.any_q      = any_q;
    sts.scan_last  = (CNT_W'(scan_r) + CNT_W'(1)) >= made_r;
    sts.dec_zero   = (dec == '0);
    sts.woke       = woke_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // event payload and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      id_r      <= in_thread_id;
      prio_in_r <= in_prio;
      ticks_r   <= TICK_BITS'(in_ticks);
      before_r  <= cur_r;
      res_r     <= ptsch_pkg::RES_OK;
      newid_r   <= '0;
      woke_r    <= 1'b0;
    end
    if (cmd.set_res) res_r <= cmd.res;
    if (cmd.make) newid_r <= sel;
    if (cmd.save_prio) pid_r <= sel_prio;
    if (cmd.scan_init) scan_r <= TID_W'(1);
    if (cmd.scan_next) scan_r <= scan_r + TID_W'(1);
    if (cmd.scan_wr && sts.dec_zero) woke_r <= 1'b1;
  end

  // thread table, queue pointers and running thread
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_THREADS; k++) begin
        st_r[k] <= (k == 1) ? ptsch_pkg::TS_RUNNING : ptsch_pkg::TS_DEAD;
        pr_r[k] <= (k == 1) ? 2'd2 : 2'd0;
      end
      for (int q = 0; q < 3; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        fill_r[q] <= '0;
      end
      cur_r  <= TID_W'(1);
      made_r <= CNT_W'(2);
    end else begin
      if (cmd.wr_status) st_r[sel] <= cmd.st_val;
      if (cmd.wr_prio) pr_r[sel] <= prio_in_r;
      if (cmd.make) made_r <= made_r + CNT_W'(1);
      if (push_ok) begin
        tail_r[pq] <= (tail_r[pq] == TID_W'(MAX_THREADS - 1)) ? '0
                                                              : tail_r[pq] + TID_W'(1);
        fill_r[pq] <= fill_r[pq] + CNT_W'(1);
      end
      if (cmd.pop_rd) begin
        head_r[hq] <= (head_r[hq] == TID_W'(MAX_THREADS - 1)) ? '0
                                                              : head_r[hq] + TID_W'(1);
        fill_r[hq] <= fill_r[hq] - CNT_W'(1);
      end
      if (cmd.set_cur) cur_r <= sel;
      if (cmd.cur_idle) cur_r <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= res_r;
      out_new_id_r   <= 4'(newid_r);
      out_running_r  <= 4'(cur_r);
      out_switched_r <= (cur_r != before_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_new_id   = out_new_id_r;
  assign out_running  = out_running_r;
  assign out_switched = out_switched_r;

  // idle thread never leaves the dead state
  a_idle_dead: assert property (@(posedge clk) disable iff (!rst_n)
    st_r[0] == ptsch_pkg::TS_DEAD)
    else $error("idle thread state changed");

  // a finished event leaves the running thread marked running
  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (cur_r == '0 || st_r[cur_r] == ptsch_pkg::TS_RUNNING))
    else $error("running thread not marked running");

  // queue fill never exceeds capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= CNT_W'(MAX_THREADS) && fill_r[1] <= CNT_W'(MAX_THREADS) &&
    fill_r[2] <= CNT_W'(MAX_THREADS))
    else $error("queue overfilled");

  // thread count stays in range
  a_made_range: assert property (@(posedge clk) disable iff (!rst_n)
    made_r >= CNT_W'(2) && made_r <= CNT_W'(MAX_THREADS))
    else $error("thread count out of range");
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int NTHR = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_EVENTS = 1700;
  localparam int HOLD_LEN = 400;

  // first member in the highest bits, so status lands in [1:0]
  typedef struct packed {
    logic       switched;
    logic [3:0] running;
    logic [3:0] new_id;
    logic [1:0] status;
  } sched_res_t;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  id;
    logic [1:0]  prio;
    logic [31:0] ticks;
    logic        has_exp;
    logic [1:0]  exp_status;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  priority_thread_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // scheduler shadow state
  logic [1:0]  thr_state [NTHR];
  logic [1:0]  thr_prio  [NTHR];
  logic [31:0] thr_sleep [NTHR];
  logic [3:0]  rdy_q [3][$];
  logic [3:0]  cur_thr;
  int          made_cnt;

  sched_res_t  sched_exp_q[$];
  int          err_cnt;
  int          word_cnt;
  int          switch_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          quiet_cycles;
  bit          hold_start;
  bit          hold_taken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d expected %0d (word %0d)", what, got, want, word_cnt);
    err_cnt++;
  endtask

  task automatic sched_reset();
    for (int i = 0; i < NTHR; i++) begin
      thr_state[i] = ptsch_pkg::TS_DEAD;
      thr_prio[i]  = 2'd0;
      thr_sleep[i] = 32'd0;
    end
    for (int q = 0; q < 3; q++) rdy_q[q].delete();
    thr_state[1] = ptsch_pkg::TS_RUNNING;
    thr_prio[1]  = 2'd2;
    cur_thr      = 4'd1;
    made_cnt     = 2;
  endtask

  task automatic ready_push(input logic [3:0] t);
    int q;
    if (thr_prio[t] == 2'd0) return;
    q = thr_prio[t] - 1;
    if (rdy_q[q].size() >= NTHR) return;
    rdy_q[q] = {rdy_q[q], t};
  endtask

  task automatic pick_next();
    logic [3:0] chosen;
    logic [3:0] t;
    bit found;
    chosen = 4'd0;
    found  = 1'b0;
    if (cur_thr != 4'd0 && thr_state[cur_thr] == ptsch_pkg::TS_RUNNING) begin
      thr_state[cur_thr] = ptsch_pkg::TS_READY;
      ready_push(cur_thr);
    end
    for (int q = 2; q >= 0 && !found; q--) begin
      while (rdy_q[q].size() > 0) begin
        t = rdy_q[q].pop_front();
        if (thr_state[t] == ptsch_pkg::TS_READY) begin
          chosen = t;
          found  = 1'b1;
          break;
        end
      end
    end
    cur_thr = chosen;
    if (chosen != 4'd0) thr_state[chosen] = ptsch_pkg::TS_RUNNING;
  endtask

  // compute the result word of one event and advance the shadow state
  task automatic sched_event(input logic [2:0] fn, input logic [3:0] id,
                             input logic [1:0] pr, input logic [31:0] tk,
                             output sched_res_t r);
    logic [3:0] prev;
    bit woke;
    prev = cur_thr;
    woke = 1'b0;
    r.status = ptsch_pkg::RES_OK;
    r.new_id = 4'd0;
    case (fn)
      ptsch_pkg::FN_CREATE: begin
        if (pr == 2'd0 || made_cnt >= NTHR) r.status = ptsch_pkg::RES_PARAM;
        else begin
          r.new_id = made_cnt[3:0];
          thr_state[made_cnt] = ptsch_pkg::TS_DEAD;
          thr_prio[made_cnt]  = pr;
          thr_sleep[made_cnt] = 32'd0;
          made_cnt++;
        end
      end
      ptsch_pkg::FN_ACTIVATE: begin
        if (id >= made_cnt) r.status = ptsch_pkg::RES_ID;
        else if (id == 4'd0 || thr_state[id] != ptsch_pkg::TS_DEAD)
          r.status = ptsch_pkg::RES_STATE;
        else begin
          thr_state[id] = ptsch_pkg::TS_READY;
          ready_push(id);
          if (thr_prio[id] > thr_prio[cur_thr]) pick_next();
        end
      end
      ptsch_pkg::FN_TERMINATE: begin
        if (id >= made_cnt) r.status = ptsch_pkg::RES_ID;
        else if (thr_state[id] == ptsch_pkg::TS_DEAD) r.status = ptsch_pkg::RES_STATE;
        else begin
          thr_state[id] = ptsch_pkg::TS_DEAD;
          thr_sleep[id] = 32'd0;
          pick_next();
        end
      end
      ptsch_pkg::FN_SLEEP: begin
        if (tk == 32'd0) r.status = ptsch_pkg::RES_PARAM;
        else if (cur_thr == 4'd0) r.status = ptsch_pkg::RES_STATE;
        else begin
          thr_sleep[cur_thr] = tk;
          thr_state[cur_thr] = ptsch_pkg::TS_WAITING;
          pick_next();
        end
      end
      ptsch_pkg::FN_TICK: begin
        for (int i = 1; i < made_cnt; i++) begin
          if (thr_state[i] == ptsch_pkg::TS_WAITING) begin
            thr_sleep[i] = thr_sleep[i] - 32'd1;
            if (thr_sleep[i] == 32'd0) begin
              thr_state[i] = ptsch_pkg::TS_READY;
              ready_push(i[3:0]);
              woke = 1'b1;
            end
          end
        end
        if (woke) pick_next();
      end
      default: r.status = ptsch_pkg::RES_PARAM;
    endcase
    r.running  = cur_thr;
    r.switched = (cur_thr != prev);
  endtask

  // drive one event and wait for its acceptance
  task automatic send_event(input logic [2:0] fn, input logic [3:0] id,
                            input logic [1:0] pr, input logic [31:0] tk,
                            input bit has_exp, input logic [1:0] exp_status);
    sched_res_t r;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, tk, pr, id, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sched_event(fn, id, pr, tk, r);
    if (has_exp && r.status != exp_status)
      report_mismatch("directed status", r.status, exp_status);
    sched_exp_q = {sched_exp_q, r};
  endtask

  function automatic logic [31:0] rand_ticks();
    case ($urandom_range(9, 0))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(6, 1);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] fn;
    logic [3:0] id;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 10)      fn = ptsch_pkg::FN_CREATE;
    else if (pick < 35) fn = ptsch_pkg::FN_ACTIVATE;
    else if (pick < 50) fn = ptsch_pkg::FN_TERMINATE;
    else if (pick < 65) fn = ptsch_pkg::FN_SLEEP;
    else if (pick < 97) fn = ptsch_pkg::FN_TICK;
    else                fn = 3'($urandom_range(7, 5));
    // mostly ids that exist
    if ($urandom_range(9, 0) < 8) id = 4'($urandom_range(made_cnt - 1, 0));
    else id = 4'($urandom());
    send_event(fn, id, 2'($urandom()), rand_ticks(), 1'b0, ptsch_pkg::RES_OK);
  endtask

  // receiver side: random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_cycles <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_start && !hold_taken) begin
      hold_cycles <= HOLD_LEN;
      hold_taken  <= 1'b1;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[10:0];
      word_cnt++;
      if (sched_exp_q.size() == 0) begin
        report_mismatch("unexpected result word", word_cnt, 0);
      end else begin
        want = sched_exp_q.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.new_id != want.new_id) report_mismatch("new_thread_id", got.new_id, want.new_id);
        if (got.running != want.running)
          report_mismatch("running_thread", got.running, want.running);
        if (got.switched != want.switched)
          report_mismatch("switched", got.switched, want.switched);
        if (want.switched) switch_cnt++;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else if (hold_cycles == 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{ptsch_pkg::FN_TICK,      4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_ACTIVATE,  4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_STATE},
    '{ptsch_pkg::FN_ACTIVATE,  4'd15, 2'd0, 32'd0,         1'b1, ptsch_pkg::RES_ID},
    '{ptsch_pkg::FN_TERMINATE, 4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_STATE},
    '{ptsch_pkg::FN_TERMINATE, 4'd15, 2'd0, 32'd0,         1'b1, ptsch_pkg::RES_ID},
    '{ptsch_pkg::FN_CREATE,    4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_PARAM},
    '{ptsch_pkg::FN_CREATE,    4'd0,  2'd3, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_CREATE,    4'd0,  2'd1, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_CREATE,    4'd15, 2'd2, 32'hFFFF_FFFF, 1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_ACTIVATE,  4'd3,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_ACTIVATE,  4'd4,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_ACTIVATE,  4'd2,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_ACTIVATE,  4'd2,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_STATE},
    '{ptsch_pkg::FN_SLEEP,     4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_PARAM},
    '{ptsch_pkg::FN_SLEEP,     4'd0,  2'd0, 32'd2,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_SLEEP,     4'd0,  2'd0, 32'hFFFF_FFFF, 1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TICK,      4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TICK,      4'd0,  2'd0, 32'd0,         1'b1, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TERMINATE, 4'd2,  2'd0, 32'd0,         1'b0, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TERMINATE, 4'd1,  2'd0, 32'd0,         1'b0, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TERMINATE, 4'd3,  2'd0, 32'd0,         1'b0, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_TERMINATE, 4'd4,  2'd0, 32'd0,         1'b0, ptsch_pkg::RES_OK},
    '{ptsch_pkg::FN_SLEEP,     4'd0,  2'd0, 32'd5,         1'b1, ptsch_pkg::RES_STATE},
    '{3'd5,                    4'd9,  2'd3, 32'hA5A5_5A5A, 1'b1, ptsch_pkg::RES_PARAM},
    '{3'd7,                    4'd6,  2'd1, 32'h5A5A_A5A5, 1'b1, ptsch_pkg::RES_PARAM}
  };

  initial begin
    int drain;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_start = 1'b0;
    err_cnt = 0;
    word_cnt = 0;
    switch_cnt = 0;
    send_idle_pct = 27;
    recv_idle_pct = 88;
    sched_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_event(dir_rows[i].func, dir_rows[i].id, dir_rows[i].prio, dir_rows[i].ticks,
                 dir_rows[i].has_exp, dir_rows[i].exp_status);

    // random phases: receiver idles, then sender idles, then neither
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == RANDOM_EVENTS / 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 27;
      end
      if (n == 2 * RANDOM_EVENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
      end
      send_random();
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (sched_exp_q.size() > 0 && drain < WATCHDOG_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d events (%0d result words, %0d thread switches)",
             dir_rows.size() + RANDOM_EVENTS, word_cnt, switch_cnt);
    $display("threads created %0d, mismatches %0d", made_cnt, err_cnt);
    if (err_cnt == 0 && sched_exp_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
